@@ hdl/cet_pkg.sv @@
// Shared types, register codes and latency figures for the cell escape time block.
`timescale 1ns / 1ps

package cet_pkg;

  // Configuration register indexes.
  typedef enum logic [7:0] {
    CFG_ENABLE         = 8'd0,
    CFG_CELL_SIZE      = 8'd1,
    CFG_CELLS_PER_SIDE = 8'd2,
    CFG_TOLERANCE      = 8'd3
  } cfg_index_t;

  localparam int LIMIT_W = 43;  // (cells_per_side - 1) * cell_size
  localparam int THR_W   = 52;  // tolerance * cell_size

  // Grid geometry shared by every axis lane; the user must keep it static while items are in flight (not enforced).
  typedef struct packed {
    logic [31:0]        cell_len;  // cell edge, zero already forced to one LSB
    logic [LIMIT_W-1:0] limit;     // lower face of the last cell
    logic [THR_W-1:0]   thr;       // on-face threshold, scaled by 2^20
  } geom_t;

  localparam int TDIV_STAGES = 32;
  localparam int TIME_LAT    = TDIV_STAGES + 2;

  function automatic int cell_lat(input int max_cells);
    return 1 + $clog2(max_cells);
  endfunction

  // Edges from the accepting edge to the edge that takes the result.
  function automatic int total_lat(input int max_cells);
    return 1 + cell_lat(max_cells) + TIME_LAT + 1;
  endfunction

endpackage

@@ hdl/cet_cell_locate.sv @@
// Pipelined cell search on one axis: clamps to the last cell, then restoring division.
`timescale 1ns / 1ps

module cet_cell_locate #(
  parameter int QW = 10
) (
  input  logic           clk,
  input  cet_pkg::geom_t geom,
  input  logic [31:0]    pos,
  input  logic [31:0]    vel,
  output logic [31:0]    dlo,
  output logic [31:0]    vel_out
);
  import cet_pkg::*;

  localparam int W = 32 + QW;

  logic [31:0] rem  [0:QW];
  logic        hold [0:QW];
  logic [31:0] velp [0:QW];
  logic        clamp;

  // In or past the last cell: take the distance from the last cell's lower face.
  assign clamp = {{(LIMIT_W-32){1'b0}}, pos} >= geom.limit;

  always_ff @(posedge clk) begin
    rem[0]  <= clamp ? pos - geom.limit[31:0] : pos;
    hold[0] <= clamp;
    velp[0] <= vel;
  end

  for (genvar gi = 0; gi < QW; gi++) begin : g_stage
    localparam int B = QW - 1 - gi;
    logic [W-1:0] sh;
    logic         take;
    assign sh   = {{QW{1'b0}}, geom.cell_len} << B;
    assign take = !hold[gi] && ({{QW{1'b0}}, rem[gi]} >= sh);
    always_ff @(posedge clk) begin
      rem[gi+1]  <= take ? rem[gi] - sh[31:0] : rem[gi];
      hold[gi+1] <= hold[gi];
      velp[gi+1] <= velp[gi];
    end
  end

  assign dlo     = rem[QW];
  assign vel_out = velp[QW];

endmodule

@@ hdl/cet_time_div.sv @@
// Face test, distance select and pipelined saturating divide for one axis time.
`timescale 1ns / 1ps

module cet_time_div (
  input  logic           clk,
  input  cet_pkg::geom_t geom,
  input  logic [31:0]    dlo,
  input  logic [31:0]    vel,
  output logic [31:0]    t
);
  import cet_pkg::*;

  logic               neg;
  logic [31:0]        mag;
  logic signed [32:0] dhi_s;
  logic [32:0]        dhi_abs;
  logic               near_lo;
  logic               near_hi;
  logic               moving;
  logic               onb;
  logic [31:0]        num;
  logic [31:0]        num_a;
  logic [31:0]        mag_a;

  logic [47:0] rem  [0:TDIV_STAGES];
  logic [31:0] magp [0:TDIV_STAGES];
  logic [31:0] quo  [0:TDIV_STAGES];
  logic        sat  [0:TDIV_STAGES];

  always_comb begin
    neg     = vel[31];
    mag     = neg ? ~vel + 32'd1 : vel;
    dhi_s   = $signed({1'b0, geom.cell_len}) - $signed({1'b0, dlo});
    dhi_abs = dhi_s[32] ? 33'(-dhi_s) : 33'(dhi_s);
    near_lo = {dlo, 20'b0} < geom.thr;
    near_hi = {dhi_abs, 20'b0} < {1'b0, geom.thr};
    moving  = mag != 32'd0;
    onb     = near_lo ? (neg && moving) : (near_hi && !neg && moving);
    if (onb) begin
      num = geom.cell_len;
    end else if (!neg) begin
      num = (!dhi_s[32] && dhi_s != 33'sd0) ? dhi_s[31:0] : 32'd0;
    end else begin
      num = dlo;
    end
  end

  always_ff @(posedge clk) begin
    num_a <= num;
    mag_a <= mag;
  end

  // Quotient of 2^32 or more saturates; zero velocity lands here too.
  always_ff @(posedge clk) begin
    rem[0]  <= {num_a, 16'b0};
    magp[0] <= mag_a;
    quo[0]  <= 32'd0;
    sat[0]  <= {16'b0, num_a} >= {mag_a, 16'b0};
  end

  for (genvar gi = 0; gi < TDIV_STAGES; gi++) begin : g_stage
    localparam int B = TDIV_STAGES - 1 - gi;
    logic [63:0] sh;
    logic        take;
    assign sh   = {32'b0, magp[gi]} << B;
    assign take = {16'b0, rem[gi]} >= sh;
    always_ff @(posedge clk) begin
      rem[gi+1]  <= take ? rem[gi] - sh[47:0] : rem[gi];
      magp[gi+1] <= magp[gi];
      quo[gi+1]  <= {quo[gi][30:0], take};
      sat[gi+1]  <= sat[gi];
    end
  end

  assign t = sat[TDIV_STAGES] ? '1 : quo[TDIV_STAGES];

endmodule

@@ hdl/cell_escape_time.sv @@
// Top level of the cell escape time pipeline: config registers, axis lanes, min and result.
`timescale 1ns / 1ps
// Depth: one cell-division stage per quotient bit and one time-division stage per bit of
//   the 32-bit quotient set the pipeline depth from the accepting edge to the edge that
//   takes the result.
// Throughput: one item per cycle; busy stays low, and the result side never stalls.
// Reset: rst (synchronous) clears every valid bit and loads the register defaults.

module cell_escape_time #(
  parameter int MAX_CELLS_PER_SIDE = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] particle_id,
  input  logic [31:0] pos_x,
  input  logic [31:0] pos_y,
  input  logic [31:0] pos_z,
  input  logic [31:0] vel_x,
  input  logic [31:0] vel_y,
  input  logic [31:0] vel_z,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        result_valid,
  output logic [15:0] result_particle_id,
  output logic [31:0] escape_time
);
  import cet_pkg::*;

  localparam int QW    = $clog2(MAX_CELLS_PER_SIDE);
  localparam int DL    = cell_lat(MAX_CELLS_PER_SIDE) + TIME_LAT;
  localparam int LC_RST = (MAX_CELLS_PER_SIDE < 4) ? MAX_CELLS_PER_SIDE : 4;
  localparam logic [16:0] MAX_L = 17'(MAX_CELLS_PER_SIDE);

  // ---------------- configuration ----------------
  logic        enable, enable_next;
  logic [10:0] lcm1, lcm1_next;     // cells per side minus one, clamped
  logic [19:0] tol, tol_next;
  logic [31:0] cell_next;
  logic [10:0] lc_raw;
  geom_t       geom;
  logic        cfg_write;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign lc_raw    = cfg_data[10:0];

  // Build next register values; derived geometry follows from them on the same edge,
  // so an item accepted right after a write already sees the new grid.
  always_comb begin
    enable_next = enable;
    cell_next   = geom.cell_len;
    lcm1_next   = lcm1;
    tol_next    = tol;
    if (cfg_write) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_ENABLE:    enable_next = cfg_data[0];
        CFG_CELL_SIZE: cell_next   = (cfg_data == 32'd0) ? 32'd1 : cfg_data;
        CFG_CELLS_PER_SIDE: begin
          if (lc_raw == 11'd0) begin
            lcm1_next = 11'd0;
          end else if ({6'b0, lc_raw} > MAX_L) begin
            lcm1_next = 11'(MAX_CELLS_PER_SIDE - 1);
          end else begin
            lcm1_next = lc_raw - 11'd1;
          end
        end
        CFG_TOLERANCE: tol_next = cfg_data[19:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enable        <= 1'b0;
      lcm1          <= 11'(LC_RST - 1);
      tol           <= 20'd1;
      geom.cell_len <= 32'h0010_0000;
      geom.limit    <= LIMIT_W'(LC_RST - 1) << 20;
      geom.thr      <= THR_W'(1) << 20;
    end else begin
      enable        <= enable_next;
      lcm1          <= lcm1_next;
      tol           <= tol_next;
      geom.cell_len <= cell_next;
      geom.limit    <= {32'b0, lcm1_next} * {11'b0, cell_next};
      geom.thr      <= {32'b0, tol_next} * {20'b0, cell_next};
    end
  end

  // ---------------- input stage ----------------
  // Every accepted item enters; with enable clear it travels as a bubble.
  assign busy = 1'b0;

  logic [31:0] pos_r [0:2];
  logic [31:0] vel_r [0:2];
  logic        vpipe [0:DL];
  logic [15:0] idpipe [0:DL];

  always_ff @(posedge clk) begin
    pos_r[0]  <= pos_x;
    pos_r[1]  <= pos_y;
    pos_r[2]  <= pos_z;
    vel_r[0]  <= vel_x;
    vel_r[1]  <= vel_y;
    vel_r[2]  <= vel_z;
    idpipe[0] <= particle_id;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe[0] <= 1'b0;
    end else begin
      vpipe[0] <= start && !busy && enable;
    end
  end

  // Carry id and valid alongside the axis lanes.
  for (genvar gs = 0; gs < DL; gs++) begin : g_side
    always_ff @(posedge clk) begin
      if (rst) begin
        vpipe[gs+1] <= 1'b0;
      end else begin
        vpipe[gs+1] <= vpipe[gs];
      end
    end
    always_ff @(posedge clk) begin
      idpipe[gs+1] <= idpipe[gs];
    end
  end

  // ---------------- axis lanes ----------------
  logic [31:0] dlo   [0:2];
  logic [31:0] vel_c [0:2];
  logic [31:0] t_ax  [0:2];

  for (genvar ga = 0; ga < 3; ga++) begin : g_axis
    cet_cell_locate #(.QW(QW)) u_locate (
      .clk     (clk),
      .geom    (geom),
      .pos     (pos_r[ga]),
      .vel     (vel_r[ga]),
      .dlo     (dlo[ga]),
      .vel_out (vel_c[ga])
    );
    cet_time_div u_tdiv (
      .clk  (clk),
      .geom (geom),
      .dlo  (dlo[ga]),
      .vel  (vel_c[ga]),
      .t    (t_ax[ga])
    );
  end

  // ---------------- min and result register ----------------
  logic [31:0] t01, t_min;

  always_comb begin
    t01   = (t_ax[0] < t_ax[1]) ? t_ax[0] : t_ax[1];
    t_min = (t_ax[2] < t01) ? t_ax[2] : t01;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= vpipe[DL];
    end
  end

  // Register the payload without reset; only the strobe says when it is live.
  always_ff @(posedge clk) begin
    result_particle_id <= idpipe[DL];
    escape_time        <= t_min;
  end

endmodule

@@ hdl/cet_checker.sv @@
// Port-level checks on the cell escape time block, bound to the top level.
`timescale 1ns / 1ps

module cet_checker #(
  parameter int MAX_CELLS_PER_SIDE = 1024
) (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic cfg_valid,
  input logic cfg_ready,
  input logic result_valid
);
  import cet_pkg::*;

  localparam int LAT = total_lat(MAX_CELLS_PER_SIDE);

  // A result traces back to an item taken earlier by the input stage.
  a_result_origin: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ($past(start, LAT) && !$past(busy, LAT)))
    else $error("result without matching accepted item");

  // Reset leaves nothing in flight.
  a_reset_flush: assert property (@(posedge clk)
    $fell(rst) |-> !result_valid)
    else $error("result right after reset");

  // Items stream without stalls.
  a_never_busy: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("input stalled");

  // Configuration writes are never held off.
  a_cfg_open: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("config write held off");

endmodule

bind cell_escape_time cet_checker #(.MAX_CELLS_PER_SIDE(MAX_CELLS_PER_SIDE)) u_cet_checker (.*);
